// ----- rtl/core/gated_sine_tone_generator_defines.svh -----
// Assertion macros for the tone burst generator checks.
`ifndef GATED_SINE_TONE_GENERATOR_DEFINES_SVH
`define GATED_SINE_TONE_GENERATOR_DEFINES_SVH

// Clocked check, off while reset is held.
`define GST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define GST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/gst_pkg.sv -----
// Shared types, constants and the quarter-wave sine table of the tone burst generator.
`timescale 1ns / 1ps

package gst_pkg;

    localparam int COUNT_BITS      = 24;
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 8;
    localparam int SAMPLE_BITS     = 16;
    localparam int STEP_BITS       = 31;
    localparam int AMP_BITS        = 15;
    localparam int MAG_BITS        = SAMPLE_BITS - 1;
    localparam int TABLE_DEPTH     = 1 << TABLE_ADDR_BITS;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 32;
    localparam int ROUND_SHIFT     = 15;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] SINE_PEAK   = (64'd1 << MAG_BITS) - 64'd1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PHASE_STEP   = 3'd0,
        CFG_PEAK_AMP     = 3'd1,
        CFG_SILENCE      = 3'd2,
        CFG_TONE_END     = 3'd3,
        CFG_TOTAL        = 3'd4
    } t_cfg_reg;

    // Stage one result handed to the lookup and scaling stages
    typedef struct packed {
        logic [1:0]                 quad;
        logic [TABLE_ADDR_BITS-1:0] addr;
        logic                       active;
        logic                       last;
    } t_phase_item;

    typedef logic [MAG_BITS-1:0] t_sine_table [TABLE_DEPTH];

    // sin(x) on [0, pi/2], Q30 in and out, truncated Taylor series
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 210;
        sum  = sum - term;
        return sum;
    endfunction

    function automatic t_sine_table build_sine_table();
        t_sine_table tbl;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] v;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            x = ((64'(2 * k) + 64'd1) * HALF_PI_Q30) >> (TABLE_ADDR_BITS + 1);
            s = sine_q30(x);
            v = (s * SINE_PEAK + (64'd1 << 29)) >> 30;
            if (v > SINE_PEAK) begin
                v = SINE_PEAK;
            end
            tbl[k] = v[MAG_BITS-1:0];
        end
        return tbl;
    endfunction

    localparam t_sine_table SINE_TABLE = build_sine_table();

endpackage

// ----- rtl/core/gated_sine_tone_generator.sv -----
// Top level of the gated sine tone burst generator: counter, phase accumulator, config.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid / tready        tdata[0] restart
//  m_axis    out  tvalid / tready        tdata[15:0] sample, tuser tone_active, tlast last
//  cfg       in   valid / ready          index (register number), data
//
//  One request per clock while the output is not stalled; each request is registered in turn by
//  the phase stage, the table read stage and the scaling stage.
//  Reset is synchronous, active low; the sine table is constant logic and needs no fill.
//  Each stage advances when the stage after it is empty or being drained.
//  Config ready is always high.
`timescale 1ns / 1ps

module gated_sine_tone_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,  // [0] restart
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [gst_pkg::SAMPLE_BITS-1:0]   o_m_axis_tdata,  // [15:0] sample
    output logic                              o_m_axis_tuser,  // [0] tone_active
    output logic                              o_m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gst_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [gst_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import gst_pkg::*;

    logic [STEP_BITS-1:0]  r_phase_step;
    logic [AMP_BITS-1:0]   r_peak_amp;
    logic [COUNT_BITS-1:0] r_silence;
    logic [COUNT_BITS-1:0] r_tone_end;
    logic [COUNT_BITS-1:0] r_total;
    logic [COUNT_BITS-1:0] r_sample_index;
    logic [PHASE_BITS-1:0] r_tone_phase;
    logic                  r_p1_valid;
    t_phase_item           r_p1;

    logic                  s2_ready;
    logic                  p1_ready;
    logic                  in_fire;
    logic [COUNT_BITS-1:0] n_index;
    logic                  n_active;
    logic                  n_last;
    logic                  n_first;
    logic [PHASE_BITS-1:0] n_phase;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_peak_amp   <= '0;
            r_silence    <= '0;
            r_tone_end   <= '0;
            r_total      <= COUNT_BITS'(1);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data[STEP_BITS-1:0];
                CFG_PEAK_AMP:   r_peak_amp   <= i_cfg_data[AMP_BITS-1:0];
                CFG_SILENCE:    r_silence    <= i_cfg_data[COUNT_BITS-1:0];
                CFG_TONE_END:   r_tone_end   <= i_cfg_data[COUNT_BITS-1:0];
                CFG_TOTAL:      r_total      <= i_cfg_data[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign p1_ready        = !r_p1_valid || s2_ready;
    assign o_s_axis_tready = p1_ready;
    assign in_fire         = i_s_axis_tvalid && p1_ready;

    always_comb begin
        n_index  = i_s_axis_tdata[0] ? COUNT_BITS'(1) : r_sample_index + COUNT_BITS'(1);
        n_active = (n_index > r_silence) && (n_index < r_tone_end);
        n_last   = (n_index == r_total);
        // first tone sample restarts the accumulator from zero
        n_first  = ({1'b0, n_index} == ({1'b0, r_silence} + (COUNT_BITS + 1)'(1)));
        if (!n_active) begin
            n_phase = '0;
        end else if (n_first) begin
            n_phase = PHASE_BITS'(r_phase_step);
        end else begin
            n_phase = r_tone_phase + PHASE_BITS'(r_phase_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_index <= '0;
            r_tone_phase   <= '0;
            r_p1_valid     <= 1'b0;
        end else begin
            if (in_fire) begin
                r_sample_index <= n_last ? '0 : n_index;
                r_tone_phase   <= n_phase;
            end
            if (p1_ready) begin
                r_p1_valid <= i_s_axis_tvalid;
            end
        end
        if (in_fire) begin
            r_p1.quad   <= n_phase[PHASE_BITS-1 -: 2];
            r_p1.addr   <= n_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
            r_p1.active <= n_active;
            r_p1.last   <= n_last;
        end
    end

    gst_sine_scale u_sine_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_p1_valid),
        .o_ready  (s2_ready),
        .i_item   (r_p1),
        .i_amp    (r_peak_amp),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_sample (o_m_axis_tdata),
        .o_active (o_m_axis_tuser),
        .o_last   (o_m_axis_tlast)
    );

endmodule

// ----- rtl/core/gst_sine_scale.sv -----
// Quarter-wave table lookup and amplitude scaling stages with the output register.
`timescale 1ns / 1ps

module gst_sine_scale (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  gst_pkg::t_phase_item            i_item,
    input  logic [gst_pkg::AMP_BITS-1:0]    i_amp,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [gst_pkg::SAMPLE_BITS-1:0] o_sample,
    output logic                            o_active,
    output logic                            o_last
);
    import gst_pkg::*;

    localparam int PROD_BITS = MAG_BITS + AMP_BITS + 1;

    logic                       r_s2_valid;
    logic [MAG_BITS-1:0]        r_s2_mag;
    logic                       r_s2_neg;
    logic                       r_s2_active;
    logic                       r_s2_last;
    logic                       r_out_valid;
    logic [SAMPLE_BITS-1:0]     r_out_sample;
    logic                       r_out_active;
    logic                       r_out_last;

    logic                       out_ready;
    logic                       s2_ready;
    logic [TABLE_ADDR_BITS-1:0] n_addr;
    logic [PROD_BITS-1:0]       n_prod;
    logic [SAMPLE_BITS-1:0]     n_mag;
    logic [SAMPLE_BITS-1:0]     n_sample;

    assign out_ready = !r_out_valid || i_ready;
    assign s2_ready  = !r_s2_valid || out_ready;
    assign o_ready   = s2_ready;

    // mirror the address in odd quadrants
    assign n_addr = i_item.quad[0] ? ~i_item.addr : i_item.addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= i_valid;
        end
        if (s2_ready && i_valid) begin
            r_s2_mag    <= SINE_TABLE[n_addr];
            r_s2_neg    <= i_item.quad[1];
            r_s2_active <= i_item.active;
            r_s2_last   <= i_item.last;
        end
    end

    always_comb begin
        n_prod = PROD_BITS'(r_s2_mag) * PROD_BITS'(i_amp) + PROD_BITS'(1 << (ROUND_SHIFT - 1));
        n_mag  = SAMPLE_BITS'(n_prod >> ROUND_SHIFT);
        if (!r_s2_active) begin
            n_sample = '0;
        end else if (r_s2_neg) begin
            n_sample = ~n_mag + SAMPLE_BITS'(1);
        end else begin
            n_sample = n_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s2_valid;
        end
        if (out_ready && r_s2_valid) begin
            r_out_sample <= n_sample;
            r_out_active <= r_s2_active;
            r_out_last   <= r_s2_last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_out_sample;
    assign o_active = r_out_active;
    assign o_last   = r_out_last;

endmodule

// ----- rtl/core/gst_port_checker.sv -----
// Port-level checks of the tone burst generator, bound to the top level.
`timescale 1ns / 1ps
`include "gated_sine_tone_generator_defines.svh"

module gst_port_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [gst_pkg::SAMPLE_BITS-1:0]   o_m_axis_tdata,
    input logic                              o_m_axis_tuser
);
    import gst_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] MOST_NEG = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    `GST_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "result dropped while stalled")
    `GST_ASSERT(a_silent_zero, o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0, "nonzero sample outside tone window")
    `GST_ASSERT(a_no_most_neg, o_m_axis_tvalid |-> o_m_axis_tdata != MOST_NEG, "sample magnitude out of range")
    `GST_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_axis_tvalid, "result valid right after reset")

endmodule

bind gated_sine_tone_generator gst_port_checker u_port_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ----- verif/gated_sine_tone_generator_tb.sv -----
// Self-checking stream testbench for the gated sine tone burst generator.
`timescale 1ns / 1ps

module gated_sine_tone_generator_tb;
    import gst_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PIPE_LATENCY = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_UNUSED = 3'd7;
    localparam logic [63:0] SINE_MAX = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   active;
        logic                   last;
    } tone_sample_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [7:0]               s_data = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b1;
    logic [SAMPLE_BITS-1:0]   m_data;
    logic                     m_user;
    logic                     m_last;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    gated_sine_tone_generator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // Predictor configuration and state
    logic [STEP_BITS-1:0]  step_cfg = '0;
    logic [AMP_BITS-1:0]   amp_cfg = '0;
    logic [COUNT_BITS-1:0] silence_cfg = '0;
    logic [COUNT_BITS-1:0] tone_end_cfg = '0;
    logic [COUNT_BITS-1:0] total_cfg = 1;
    logic [COUNT_BITS-1:0] burst_pos = '0;
    logic [PHASE_BITS-1:0] osc_phase = '0;
    logic [MAG_BITS-1:0]   quarter_sine [TABLE_DEPTH];

    tone_sample_t expected_samples[$];
    logic         restart_backlog[$];

    int items_queued = 0;
    int items_taken = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_gap = 0;
    int recv_gap = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] taylor_sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int i = 1; i <= 7; i++) begin
            term = ((term * x2) >> 30) / (64'(2 * i) * 64'(2 * i + 1));
            if (i % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    initial begin
        logic [63:0] x;
        logic [63:0] v;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            x = ((64'(2 * k) + 64'd1) * 64'd1686629713) >> (TABLE_ADDR_BITS + 1);
            v = (taylor_sine_q30(x) * SINE_MAX + (64'd1 << 29)) >> 30;
            if (v > SINE_MAX) begin
                v = SINE_MAX;
            end
            quarter_sine[k] = v[MAG_BITS-1:0];
        end
    end

    function automatic tone_sample_t predict_tone_sample(input logic restart);
        logic [COUNT_BITS-1:0] n;
        logic [PHASE_BITS-1:0] base;
        logic [1:0]            quad;
        logic [TABLE_ADDR_BITS-1:0] addr;
        logic [31:0]           mag;
        tone_sample_t          r;
        n = restart ? COUNT_BITS'(1) : burst_pos + COUNT_BITS'(1);
        r.active = (n > silence_cfg) && (n < tone_end_cfg);
        r.last   = (n == total_cfg);
        r.sample = '0;
        if (r.active) begin
            // tone restarts its phase on the first sample after the silence
            base = ({1'b0, n} == {1'b0, silence_cfg} + 1) ? '0 : osc_phase;
            osc_phase = base + PHASE_BITS'(step_cfg);
            quad = osc_phase[PHASE_BITS-1 -: 2];
            addr = osc_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
            if (quad[0]) begin
                addr = ~addr;
            end
            mag = (32'(quarter_sine[addr]) * 32'(amp_cfg) + 32'd16384) >> ROUND_SHIFT;
            r.sample = quad[1] ? SAMPLE_BITS'(32'd0 - mag) : mag[SAMPLE_BITS-1:0];
        end else begin
            osc_phase = '0;
        end
        burst_pos = r.last ? '0 : n;
        return r;
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        logic next_valid;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_samples.push_back(predict_tone_sample(s_data[0]));
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                next_valid = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (restart_backlog.size() > 0) begin
                    if ($urandom_range(99) < send_idle_pct) begin
                        send_gap = $urandom_range(0, 11);
                    end else begin
                        next_valid = 1'b1;
                        s_data <= {7'b0, restart_backlog.pop_front()};
                    end
                end
                s_valid <= next_valid;
            end
        end
    end

    task automatic compare_field(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // Result monitor and back-pressure
    always @(posedge i_clk) begin
        tone_sample_t want;
        if (i_rst_n) begin
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected result, sample expected none got %h",
                             $time, m_data);
                    fail_count++;
                end else begin
                    want = expected_samples.pop_front();
                    compare_field("sample", want.sample, m_data);
                    compare_field("tone_active", 16'(want.active), 16'(m_user));
                    compare_field("last", 16'(want.last), 16'(m_last));
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if ($urandom_range(99) < recv_idle_pct) begin
                recv_gap = $urandom_range(0, 11);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Register writes into the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PHASE_STEP: step_cfg = cfg_data[STEP_BITS-1:0];
                CFG_PEAK_AMP:   amp_cfg = cfg_data[AMP_BITS-1:0];
                CFG_SILENCE:    silence_cfg = cfg_data[COUNT_BITS-1:0];
                CFG_TONE_END:   tone_end_cfg = cfg_data[COUNT_BITS-1:0];
                CFG_TOTAL:      total_cfg = cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic void push_item(input logic restart);
        restart_backlog.push_back(restart);
        items_queued++;
    endfunction

    task automatic wait_idle();
        while (items_taken != items_queued || expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic randomize_config();
        logic [31:0] lim;
        logic [31:0] hi;
        hi = $urandom & 32'hFF00_0000;
        case ($urandom_range(4))
            0: write_reg(CFG_PHASE_STEP, 32'd0);
            1: write_reg(CFG_PHASE_STEP, 32'h7FFF_FFFF);
            2: write_reg(CFG_PHASE_STEP, $urandom_range(0, 32'h0010_0000));
            default: write_reg(CFG_PHASE_STEP, $urandom);
        endcase
        case ($urandom_range(3))
            0: write_reg(CFG_PEAK_AMP, 32'd0);
            1: write_reg(CFG_PEAK_AMP, 32'd32767);
            default: write_reg(CFG_PEAK_AMP, $urandom);
        endcase
        lim = $urandom_range(1, 40);
        case ($urandom_range(11))
            0: write_reg(CFG_TOTAL, $urandom);
            1: write_reg(CFG_TOTAL, hi);
            default: write_reg(CFG_TOTAL, hi | lim);
        endcase
        if ($urandom_range(7) == 0) begin
            write_reg(CFG_SILENCE, $urandom);
            write_reg(CFG_TONE_END, $urandom);
        end else begin
            write_reg(CFG_SILENCE, hi | $urandom_range(0, lim));
            write_reg(CFG_TONE_END, hi | $urandom_range(0, lim + 3));
        end
        if ($urandom_range(5) == 0) begin
            write_reg(CFG_IDX_UNUSED, $urandom);
        end
    endtask

    initial begin
        int count;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 20;
        recv_idle_pct = 20;

        // reset values: every sample is a one-sample burst
        push_item(1'b0);
        push_item(1'b1);
        push_item(1'b0);
        wait_idle();

        // full-scale step and amplitude, window to the burst start, restart mid-burst
        write_reg(CFG_PHASE_STEP, 32'h7FFF_FFFF);
        write_reg(CFG_PEAK_AMP, 32'd32767);
        write_reg(CFG_SILENCE, 32'd0);
        write_reg(CFG_TONE_END, 32'd8);
        write_reg(CFG_TOTAL, 32'd9);
        for (int i = 0; i < 11; i++) begin
            push_item(i == 5);
        end
        wait_idle();

        // quarter-cycle step walks all quadrants; window runs past burst end
        write_reg(CFG_PHASE_STEP, 32'h4000_0000);
        write_reg(CFG_SILENCE, 32'd1);
        write_reg(CFG_TONE_END, 32'd7);
        write_reg(CFG_TOTAL, 32'd6);
        for (int i = 0; i < 7; i++) begin
            push_item(i == 0);
        end
        wait_idle();

        // empty window, then total shrunk below the running index
        write_reg(CFG_SILENCE, 32'd3);
        write_reg(CFG_TONE_END, 32'd4);
        write_reg(CFG_TOTAL, 32'd5);
        push_item(1'b1);
        push_item(1'b0);
        push_item(1'b0);
        wait_idle();
        write_reg(CFG_TOTAL, 32'd2);
        push_item(1'b0);
        push_item(1'b0);
        push_item(1'b1);
        push_item(1'b0);
        wait_idle();

        // zero total never marks last
        write_reg(CFG_TOTAL, 32'd0);
        write_reg(CFG_TONE_END, 32'd0);
        write_reg(CFG_IDX_UNUSED, 32'hFFFF_FFFF);
        push_item(1'b1);
        push_item(1'b0);
        push_item(1'b0);
        wait_idle();

        for (int p = 0; p < 16; p++) begin
            if (p >= 14) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                case ($urandom_range(2))
                    0: send_idle_pct = 0;
                    1: send_idle_pct = 10;
                    default: send_idle_pct = 35;
                endcase
                case ($urandom_range(2))
                    0: recv_idle_pct = 0;
                    1: recv_idle_pct = 10;
                    default: recv_idle_pct = 35;
                endcase
            end
            randomize_config();
            count = $urandom_range(80, 130);
            for (int i = 0; i < count; i++) begin
                push_item($urandom_range(15) == 0);
            end
            wait_idle();
        end

        repeat (PIPE_LATENCY + 5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
